### rtl/edtd_pkg.sv
// Shared types and constants for the EDID timing entry decoder.
package edtd_pkg;

   localparam int FIFO_DEPTH = 2;

   localparam logic CMD_STANDARD = 1'b0;
   localparam logic CMD_DETAILED = 1'b1;

   localparam logic [1:0] ST_VALID      = 2'd0;
   localparam logic [1:0] ST_NONE       = 2'd1;
   localparam logic [1:0] ST_ZERO_TOTAL = 2'd2;

   localparam logic [1:0] ASPECT_16_10 = 2'd0;
   localparam logic [1:0] ASPECT_4_3   = 2'd1;
   localparam logic [1:0] ASPECT_5_4   = 2'd2;
   localparam logic [1:0] ASPECT_16_9  = 2'd3;

   localparam int SIZE_W    = 12;
   localparam int TOTAL_W   = 13;
   localparam int CLK_W     = 16;
   localparam int REFRESH_W = 10;
   localparam int REM_W     = 30;
   localparam int PROD_W    = 2 * TOTAL_W;
   localparam int CMP_W     = PROD_W + REFRESH_W;

   localparam logic [REFRESH_W-1:0] REFRESH_MAX = '1;
   localparam int CLK_SCALE      = 10000;
   localparam int STD_WIDTH_BIAS = 31;
   localparam int STD_RATE_BIAS  = 60;
   localparam int RECIP_5        = 13108;   // ceil(2^16 / 5), exact for 12-bit values

   typedef struct packed {
      logic [1:0]           status;
      logic [SIZE_W-1:0]    width;
      logic [SIZE_W-1:0]    height;
      logic [REFRESH_W-1:0] refresh;
      logic                 do_div;
      logic [CLK_W-1:0]     clk;
      logic [TOTAL_W-1:0]   htot;
      logic [TOTAL_W-1:0]   vtot;
   } entry_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [SIZE_W-1:0]    width;
      logic [SIZE_W-1:0]    height;
      logic [REFRESH_W-1:0] refresh;
      logic                 do_div;
      logic                 sat;
      logic [REM_W-1:0]     rem;
      logic [PROD_W-1:0]    tot;
      logic [REFRESH_W-1:0] quo;
   } stage_type;

endpackage

### rtl/edtd_front.sv
// Front end: accepts an entry and classifies and unpacks it for the back end.
module edtd_front (
   input  logic                 req_command,
   input  logic [7:0]           req_desc_b0,
   input  logic [7:0]           req_desc_b1,
   input  logic [7:0]           req_desc_b2,
   input  logic [7:0]           req_desc_b3,
   input  logic [7:0]           req_desc_b4,
   input  logic [7:0]           req_desc_b5,
   input  logic [7:0]           req_desc_b6,
   input  logic [7:0]           req_desc_b7,
   output edtd_pkg::entry_type  entry
);

   logic [edtd_pkg::SIZE_W-1:0]  std_w;
   logic [edtd_pkg::SIZE_W-1:0]  std_h;
   logic [edtd_pkg::SIZE_W-1:0]  w16;
   logic [edtd_pkg::SIZE_W-1:0]  w4;
   logic [edtd_pkg::SIZE_W-1:0]  w5;
   logic [27:0]                  w5_prod;
   logic [edtd_pkg::SIZE_W-1:0]  hact;
   logic [edtd_pkg::SIZE_W-1:0]  hblk;
   logic [edtd_pkg::SIZE_W-1:0]  vact;
   logic [edtd_pkg::SIZE_W-1:0]  vblk;
   logic [edtd_pkg::TOTAL_W-1:0] htot;
   logic [edtd_pkg::TOTAL_W-1:0] vtot;

   assign std_w = (edtd_pkg::SIZE_W'(req_desc_b0) +
                   edtd_pkg::SIZE_W'(edtd_pkg::STD_WIDTH_BIAS)) << 3;
   assign w16 = std_w >> 4;
   assign w4  = std_w >> 2;
   // divide by five through a reciprocal multiply
   assign w5_prod = 28'(std_w) * 28'(edtd_pkg::RECIP_5);
   assign w5      = w5_prod[16 +: edtd_pkg::SIZE_W];

   always_comb begin
      case (req_desc_b1[7:6])
         edtd_pkg::ASPECT_16_10: std_h = (w16 << 3) + (w16 << 1);
         edtd_pkg::ASPECT_4_3:   std_h = (w4 << 1) + w4;
         edtd_pkg::ASPECT_5_4:   std_h = w5 << 2;
         edtd_pkg::ASPECT_16_9:  std_h = (w16 << 3) + w16;
         default:                std_h = '0;
      endcase
   end

   assign hact = {req_desc_b4[7:4], req_desc_b2};
   assign hblk = {req_desc_b4[3:0], req_desc_b3};
   assign vact = {req_desc_b7[7:4], req_desc_b5};
   assign vblk = {req_desc_b7[3:0], req_desc_b6};
   assign htot = edtd_pkg::TOTAL_W'(hact) + edtd_pkg::TOTAL_W'(hblk);
   assign vtot = edtd_pkg::TOTAL_W'(vact) + edtd_pkg::TOTAL_W'(vblk);

   always_comb begin
      entry        = '0;
      entry.clk    = {req_desc_b1, req_desc_b0};
      entry.htot   = htot;
      entry.vtot   = vtot;
      if (req_command == edtd_pkg::CMD_STANDARD) begin
         if (req_desc_b0 == 8'd1 && req_desc_b1 == 8'd1) begin
            entry.status = edtd_pkg::ST_NONE;
         end else begin
            entry.status  = edtd_pkg::ST_VALID;
            entry.width   = std_w;
            entry.height  = std_h;
            entry.refresh = edtd_pkg::REFRESH_W'(req_desc_b1[5:0]) +
                            edtd_pkg::REFRESH_W'(edtd_pkg::STD_RATE_BIAS);
         end
      end else begin
         if (req_desc_b0 == 8'd0 && req_desc_b1 == 8'd0 &&
             req_desc_b2 == 8'd0 && req_desc_b4 == 8'd0) begin
            // monitor descriptor, not a timing
            entry.status = edtd_pkg::ST_NONE;
         end else if (htot == '0 || vtot == '0) begin
            entry.status = edtd_pkg::ST_ZERO_TOTAL;
            entry.width  = hact;
            entry.height = vact;
         end else begin
            entry.status = edtd_pkg::ST_VALID;
            entry.width  = hact;
            entry.height = vact;
            entry.do_div = 1'b1;
         end
      end
   end

endmodule

### rtl/edtd_fifo.sv
// Short item queue between the front end and the back end.
module edtd_fifo #(
   parameter int DEPTH = edtd_pkg::FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  edtd_pkg::entry_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output edtd_pkg::entry_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   edtd_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;
   logic                pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### rtl/edtd_back.sv
// Back end: multiplies, checks saturation and divides one quotient bit per stage.
module edtd_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  edtd_pkg::entry_type              in_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [edtd_pkg::SIZE_W-1:0]      rsp_width,
   output logic [edtd_pkg::SIZE_W-1:0]      rsp_height,
   output logic [edtd_pkg::REFRESH_W-1:0]   rsp_refresh
);

   localparam int DIV_BITS = edtd_pkg::REFRESH_W;
   localparam int NUM_ST   = DIV_BITS + 2;

   edtd_pkg::stage_type stage_ff [NUM_ST];
   edtd_pkg::stage_type stage_in [NUM_ST];
   logic [NUM_ST-1:0]   vld_ff;
   logic                out_vld_ff;
   logic [1:0]                     out_status_ff;
   logic [edtd_pkg::SIZE_W-1:0]    out_width_ff;
   logic [edtd_pkg::SIZE_W-1:0]    out_height_ff;
   logic [edtd_pkg::REFRESH_W-1:0] out_refresh_ff, out_refresh_in;
   logic                advance;
   logic [edtd_pkg::CMP_W-1:0] sat_rate;
   logic [edtd_pkg::CMP_W-1:0] sat_lim;

   // the whole pipe moves unless a finished item is stuck at the output
   assign advance  = !out_vld_ff || rsp_ready;
   assign in_ready = advance;

   always_comb begin
      stage_in[0]         = '0;
      stage_in[0].status  = in_data.status;
      stage_in[0].width   = in_data.width;
      stage_in[0].height  = in_data.height;
      stage_in[0].refresh = in_data.refresh;
      stage_in[0].do_div  = in_data.do_div;
      stage_in[0].rem     = edtd_pkg::REM_W'(in_data.clk) *
                            edtd_pkg::REM_W'(edtd_pkg::CLK_SCALE);
      stage_in[0].tot     = edtd_pkg::PROD_W'(in_data.htot) *
                            edtd_pkg::PROD_W'(in_data.vtot);
   end

   // refresh above the max iff rate >= total * 2^DIV_BITS
   assign sat_rate = edtd_pkg::CMP_W'(stage_ff[0].rem);
   assign sat_lim  = {stage_ff[0].tot, {DIV_BITS{1'b0}}};

   always_comb begin
      stage_in[1]     = stage_ff[0];
      stage_in[1].sat = sat_rate >= sat_lim;
   end

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      localparam int BIT = DIV_BITS - 1 - k;
      logic [edtd_pkg::CMP_W-1:0] rem_w;
      logic [edtd_pkg::CMP_W-1:0] dsh_w;
      logic [edtd_pkg::CMP_W-1:0] diff_w;

      assign rem_w  = edtd_pkg::CMP_W'(stage_ff[k+1].rem);
      assign dsh_w  = edtd_pkg::CMP_W'(stage_ff[k+1].tot) << BIT;
      assign diff_w = rem_w - dsh_w;

      always_comb begin
         stage_in[k+2] = stage_ff[k+1];
         if (rem_w >= dsh_w) begin
            stage_in[k+2].rem      = diff_w[edtd_pkg::REM_W-1:0];
            stage_in[k+2].quo[BIT] = 1'b1;
         end
      end
   end

   always_comb begin
      if (!stage_ff[NUM_ST-1].do_div) begin
         out_refresh_in = stage_ff[NUM_ST-1].refresh;
      end else if (stage_ff[NUM_ST-1].sat) begin
         out_refresh_in = edtd_pkg::REFRESH_MAX;
      end else begin
         out_refresh_in = stage_ff[NUM_ST-1].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= {vld_ff[NUM_ST-2:0], in_valid};
         out_vld_ff <= vld_ff[NUM_ST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < NUM_ST; s++) begin
            stage_ff[s] <= stage_in[s];
         end
         out_status_ff  <= stage_ff[NUM_ST-1].status;
         out_width_ff   <= stage_ff[NUM_ST-1].width;
         out_height_ff  <= stage_ff[NUM_ST-1].height;
         out_refresh_ff <= out_refresh_in;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_width   = out_width_ff;
   assign rsp_height  = out_height_ff;
   assign rsp_refresh = out_refresh_ff;

endmodule

### rtl/edid_timing_decoder_top.sv
// Throughput: one item per cycle unless rsp_ready stalls the output; the back end is a
// 12-stage pipe (multiply, saturation check, ten restoring divide stages, one quotient
// bit each) plus an output register.
// The front end pushes into a small queue, so req_ready drops only when it is full.
// Reset (synchronous, active high) empties the queue and clears all pipe valid bits.
// Top level of the EDID timing entry decoder.
module edid_timing_decoder_top #(
   parameter int FIFO_DEPTH = edtd_pkg::FIFO_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [7:0]                     req_desc_b0,
   input  logic [7:0]                     req_desc_b1,
   input  logic [7:0]                     req_desc_b2,
   input  logic [7:0]                     req_desc_b3,
   input  logic [7:0]                     req_desc_b4,
   input  logic [7:0]                     req_desc_b5,
   input  logic [7:0]                     req_desc_b6,
   input  logic [7:0]                     req_desc_b7,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [edtd_pkg::SIZE_W-1:0]    rsp_width,
   output logic [edtd_pkg::SIZE_W-1:0]    rsp_height,
   output logic [edtd_pkg::REFRESH_W-1:0] rsp_refresh
);

   edtd_pkg::entry_type front_entry;
   edtd_pkg::entry_type queue_entry;
   logic                queue_valid;
   logic                queue_ready;

   edtd_front u_front (
      .req_command (req_command),
      .req_desc_b0 (req_desc_b0),
      .req_desc_b1 (req_desc_b1),
      .req_desc_b2 (req_desc_b2),
      .req_desc_b3 (req_desc_b3),
      .req_desc_b4 (req_desc_b4),
      .req_desc_b5 (req_desc_b5),
      .req_desc_b6 (req_desc_b6),
      .req_desc_b7 (req_desc_b7),
      .entry       (front_entry)
   );

   edtd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (front_entry),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_entry)
   );

   edtd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (queue_valid),
      .in_ready    (queue_ready),
      .in_data     (queue_entry),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_width   (rsp_width),
      .rsp_height  (rsp_height),
      .rsp_refresh (rsp_refresh)
   );

endmodule
